/* hw/rtl/f3v_pkg.sv */
package f3v_pkg;

	localparam int F3V_QUEUE_DEPTH = 2;

	localparam logic [2:0] CFG_X_MIN       = 3'd0;
	localparam logic [2:0] CFG_Y_MIN       = 3'd1;
	localparam logic [2:0] CFG_Z_MIN       = 3'd2;
	localparam logic [2:0] CFG_VOXEL_STEP  = 3'd3;
	localparam logic [2:0] CFG_BAILOUT     = 3'd4;
	localparam logic [2:0] CFG_MAX_ITER    = 3'd5;
	localparam logic [2:0] CFG_FOLD_FIRST  = 3'd6;
	localparam logic [2:0] CFG_FOLD_SECOND = 3'd7;

	localparam logic [30:0] BAILOUT_RESET  = 31'd67108864;
	localparam logic [15:0] MAX_ITER_RESET = 16'd64;

	localparam logic [15:0] CAP_048  = 16'd31457;
	localparam logic [15:0] HALF_016 = 16'd32768;

	typedef struct packed {
		logic [9:0] x_index;
		logic [9:0] y_index;
		logic [9:0] z_index;
	} f3v_in_t;

	typedef struct packed {
		logic [15:0] voxel_value;
		logic        escaped;
		logic [15:0] iteration_count;
	} f3v_out_t;

	typedef struct packed {
		logic signed [31:0] x_min;
		logic signed [31:0] y_min;
		logic signed [31:0] z_min;
		logic [30:0]        voxel_step;
		logic [30:0]        bailout;
		logic [15:0]        max_iter;
		logic [3:0]         fold_first;
		logic [3:0]         fold_second;
	} f3v_cfg_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
	} f3v_start_t;

	// {overflow, saturated Q8.24}
	function automatic logic [32:0] sat_q(input logic signed [47:0] v);
		logic [32:0] r;
		if (v > 48'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -48'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = {v[31], v};
		return v[31] ? -e : e;
	endfunction

	function automatic logic signed [31:0] start_coord(input logic signed [31:0] lo,
			input logic [9:0] idx, input logic [30:0] step);
		logic [41:0]        prod;
		logic signed [47:0] sum;
		logic [32:0]        s;
		prod = {idx, 1'b1} * step;
		sum  = {{16{lo[31]}}, lo} + $signed({7'd0, prod[41:1]});
		s    = sat_q(sum);
		return s[31:0];
	endfunction

endpackage

/* hw/rtl/f3v_front.sv */
module f3v_front import f3v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  f3v_in_t    voxel,
	input  f3v_cfg_t   cfg,
	input  logic       q_full,
	output logic       busy,
	output logic       push,
	output f3v_start_t push_data
);

	logic    vld_q;
	f3v_in_t idx_s1;
	logic    accept;

	assign busy   = vld_q & q_full;
	assign push   = vld_q & ~q_full;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= accept | (vld_q & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= voxel;
		end
	end

	assign push_data.cx = start_coord(cfg.x_min, idx_s1.x_index, cfg.voxel_step);
	assign push_data.cy = start_coord(cfg.y_min, idx_s1.y_index, cfg.voxel_step);
	assign push_data.cz = start_coord(cfg.z_min, idx_s1.z_index, cfg.voxel_step);

endmodule

/* hw/rtl/f3v_queue.sv */
module f3v_queue import f3v_pkg::*; #(
	parameter int DEPTH = F3V_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  f3v_start_t push_data,
	output logic       full,
	input  logic       pop,
	output f3v_start_t pop_data,
	output logic       empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	f3v_start_t    mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/f3v_engine.sv */
module f3v_engine import f3v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  f3v_cfg_t   cfg,
	input  logic       q_empty,
	input  f3v_start_t q_data,
	output logic       pop,
	output f3v_out_t   result,
	output logic       result_valid
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_SUM   = 4'd2;
	localparam logic [3:0] ST_SQR   = 4'd3;
	localparam logic [3:0] ST_CHK   = 4'd4;
	localparam logic [3:0] ST_SQRT  = 4'd5;
	localparam logic [3:0] ST_SCALE = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]         state_q;
	logic signed [31:0] cx_q, cy_q, cz_q, x_q, y_q, z_q, nx_q, ny_q, nz_q;
	logic               ovf_q, first_q, esc_q;
	logic [15:0]        iter_q;
	logic signed [63:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q;
	logic signed [63:0] sq0_q, sq1_q, sq2_q;
	logic [63:0]        mag2_q;
	logic [61:0]        bail2_q;
	logic [63:0]        sn_q, sres_q, sbit_q;
	logic [5:0]         cnt_q;
	logic [46:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [30:0]        dvs_q;
	f3v_out_t           res_q;

	// multiply stage operands
	logic signed [32:0] ax1, ax2, by, bz;
	logic signed [65:0] pxy_w, pxz_w;
	// sum stage
	logic signed [47:0] x2, y2, z2, ra, rb, nxw, qy, qz, nyw, nzw;
	logic [32:0]        sx, sy, sz;
	// check stage
	logic [63:0]        m2;
	logic               gt;
	// root and divide steps
	logic [63:0]        st;
	logic               sge;
	logic [32:0]        rsh;
	logic               dge;
	logic [31:0]        rnew;
	logic [15:0]        iter_nx;

	assign pop          = (state_q == ST_IDLE) && !q_empty;
	assign result       = res_q;
	assign result_valid = (state_q == ST_OUT);

	always_comb begin
		ax1   = cfg.fold_first[1]  ? abs33(x_q) : {x_q[31], x_q};
		ax2   = cfg.fold_second[1] ? abs33(x_q) : {x_q[31], x_q};
		by    = cfg.fold_first[2]  ? abs33(y_q) : {y_q[31], y_q};
		bz    = cfg.fold_second[2] ? abs33(z_q) : {z_q[31], z_q};
		pxy_w = ax1 * by;
		pxz_w = ax2 * bz;

		x2 = $signed({8'd0, pxx_q[63:24]});
		y2 = $signed({8'd0, pyy_q[63:24]});
		z2 = $signed({8'd0, pzz_q[63:24]});
		ra = x2 - y2;
		rb = x2 - z2;
		if (cfg.fold_first[0] && ra[47]) begin
			ra = -ra;
		end
		if (cfg.fold_second[0] && rb[47]) begin
			rb = -rb;
		end
		nxw = ra + rb - x2 + {{16{cx_q[31]}}, cx_q};
		qy  = 48'(pxy_q >>> 23);
		qz  = 48'(pxz_q >>> 23);
		if (cfg.fold_first[3]) begin
			qy = -qy;
		end
		if (cfg.fold_second[3]) begin
			qz = -qz;
		end
		nyw = qy + {{16{cy_q[31]}}, cy_q};
		nzw = qz + {{16{cz_q[31]}}, cz_q};
		sx  = sat_q(nxw);
		sy  = sat_q(nyw);
		sz  = sat_q(nzw);

		m2 = 64'(sq0_q) + 64'(sq1_q) + 64'(sq2_q);
		gt = m2 > {2'b00, bail2_q};

		st  = sres_q + sbit_q;
		sge = sn_q >= st;

		rsh  = {rem_q, dvd_q[46]};
		dge  = rsh >= {2'b00, dvs_q};
		rnew = dge ? 32'(rsh - {2'b00, dvs_q}) : rsh[31:0];

		iter_nx = iter_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_SQR;
				ST_SQR:   state_q <= ST_CHK;
				ST_CHK: begin
					if (first_q) begin
						if (cfg.max_iter == '0) begin
							state_q <= (cfg.bailout == '0) ? ST_OUT : ST_SQRT;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (ovf_q || gt) begin
						state_q <= ST_DIV;
					end else if (iter_nx == cfg.max_iter) begin
						state_q <= (cfg.bailout == '0) ? ST_OUT : ST_SQRT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bail2_q <= cfg.bailout * cfg.bailout;
				cx_q    <= q_data.cx;
				cy_q    <= q_data.cy;
				cz_q    <= q_data.cz;
				nx_q    <= q_data.cx;
				ny_q    <= q_data.cy;
				nz_q    <= q_data.cz;
				ovf_q   <= 1'b0;
				first_q <= 1'b1;
				esc_q   <= 1'b0;
				iter_q  <= '0;
			end
			ST_MUL: begin
				pxx_q <= x_q * x_q;
				pyy_q <= y_q * y_q;
				pzz_q <= z_q * z_q;
				pxy_q <= pxy_w[63:0];
				pxz_q <= pxz_w[63:0];
			end
			ST_SUM: begin
				nx_q  <= sx[31:0];
				ny_q  <= sy[31:0];
				nz_q  <= sz[31:0];
				ovf_q <= sx[32] | sy[32] | sz[32];
			end
			ST_SQR: begin
				sq0_q <= nx_q * nx_q;
				sq1_q <= ny_q * ny_q;
				sq2_q <= nz_q * nz_q;
			end
			ST_CHK: begin
				if (!first_q && (ovf_q || gt)) begin
					esc_q <= 1'b1;
					dvd_q <= {16'd0, iter_q, 15'd0};
					dvs_q <= {15'd0, cfg.max_iter};
					rem_q <= '0;
					cnt_q <= 6'd46;
				end else begin
					first_q <= 1'b0;
					x_q     <= nx_q;
					y_q     <= ny_q;
					z_q     <= nz_q;
					sn_q    <= m2;
					sres_q  <= '0;
					sbit_q  <= 64'd1 << 62;
					cnt_q   <= 6'd31;
					if (!first_q) begin
						iter_q <= iter_nx;
					end
					res_q.voxel_value     <= CAP_048;
					res_q.escaped         <= 1'b0;
					res_q.iteration_count <= cfg.max_iter;
				end
			end
			ST_SQRT: begin
				if (sge) begin
					sn_q   <= sn_q - st;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_SCALE: begin
				dvd_q <= sres_q[31:0] * CAP_048[14:0];
				dvs_q <= cfg.bailout;
				rem_q <= '0;
				cnt_q <= 6'd46;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[45:0], dge};
				rem_q <= rnew;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					if (esc_q) begin
						res_q.voxel_value     <= HALF_016 + {dvd_q[14:0], dge};
						res_q.escaped         <= 1'b1;
						res_q.iteration_count <= iter_q;
					end else if ({dvd_q[45:0], dge} < {31'd0, CAP_048}) begin
						res_q.voxel_value <= {dvd_q[14:0], dge};
					end else begin
						res_q.voxel_value <= CAP_048;
					end
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/folded_3d_escape_time_voxel_top.sv */
// Folded 3D escape-time voxel evaluator. Pulse start with a voxel index while
// busy is low; one result per voxel appears on result for a single cycle with
// result_valid high, in input order, and must be captured then. Each orbit
// iteration steps through the multiply, sum, square and bailout check states.
// A voxel that stays bounded then takes a square root, a scaling step and a
// division (all skipped when bailout is zero); one that escapes takes only the
// division. The single iteration engine works on one voxel at a time. A short
// start-point queue lets new voxels enter while the engine works.
module folded_3d_escape_time_voxel_top import f3v_pkg::*; #(
	parameter int QUEUE_DEPTH = F3V_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  f3v_in_t     voxel,
	output f3v_out_t    result,
	output logic        result_valid,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	f3v_cfg_t   cfg_q;
	logic       q_full, q_empty, push, pop;
	f3v_start_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min       <= '0;
			cfg_q.y_min       <= '0;
			cfg_q.z_min       <= '0;
			cfg_q.voxel_step  <= '0;
			cfg_q.bailout     <= BAILOUT_RESET;
			cfg_q.max_iter    <= MAX_ITER_RESET;
			cfg_q.fold_first  <= '0;
			cfg_q.fold_second <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_MIN:       cfg_q.x_min       <= cfg_wdata;
				CFG_Y_MIN:       cfg_q.y_min       <= cfg_wdata;
				CFG_Z_MIN:       cfg_q.z_min       <= cfg_wdata;
				CFG_VOXEL_STEP:  cfg_q.voxel_step  <= cfg_wdata[30:0];
				CFG_BAILOUT:     cfg_q.bailout     <= cfg_wdata[30:0];
				CFG_MAX_ITER:    cfg_q.max_iter    <= cfg_wdata[15:0];
				CFG_FOLD_FIRST:  cfg_q.fold_first  <= cfg_wdata[3:0];
				CFG_FOLD_SECOND: cfg_q.fold_second <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	f3v_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.voxel     (voxel),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	f3v_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	f3v_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

/* tb/tb.sv */
module tb;
	import f3v_pkg::*;

	localparam int WATCHDOG_LIMIT = 1200000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int RANDOM_ITEMS   = 1030;
	localparam int CALM_TAIL      = 120;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] reg_data;
		f3v_in_t     vox;
		bit          typed;
		f3v_out_t    known;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	f3v_in_t     voxel = '0;
	f3v_out_t    result;
	logic        result_valid;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	folded_3d_escape_time_voxel_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .voxel(voxel),
		.result(result), .result_valid(result_valid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block's registers
	longint          sh_xmin, sh_ymin, sh_zmin;
	longint unsigned sh_step, sh_bail, sh_iter;
	logic [3:0]      sh_fold1, sh_fold2;

	f3v_out_t pending_voxels[$];
	int       errors = 0;
	int       idle_cycles = 0;

	function automatic longint sat_coord(longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint seed_coord(longint lo, logic [9:0] idx);
		bit              dummy;
		longint unsigned off;
		dummy = 1'b0;
		off = ((2 * longint'(idx) + 1) * sh_step) >> 1;
		return sat_coord(lo + longint'(off), dummy);
	endfunction

	function automatic longint cross_term(longint x, longint axis, logic [3:0] f);
		longint a, b, q;
		a = f[1] ? abs_l(x) : x;
		b = f[2] ? abs_l(axis) : axis;
		q = (a * b) >>> 23;
		return f[3] ? -q : q;
	endfunction

	function automatic longint unsigned norm2(longint a, longint b, longint c);
		return longint'(a * a) + longint'(b * b) + longint'(c * c);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic f3v_out_t eval_voxel(f3v_in_t v);
		longint          cx, cy, cz, x, y, z, x2, y2, z2, ra, rb, nx, ny, nz;
		longint unsigned bail2, it, mag, t, val;
		bit              esc, ovf;
		f3v_out_t        r;
		cx = seed_coord(sh_xmin, v.x_index);
		cy = seed_coord(sh_ymin, v.y_index);
		cz = seed_coord(sh_zmin, v.z_index);
		x = cx; y = cy; z = cz;
		bail2 = sh_bail * sh_bail;
		esc = 1'b0;
		for (it = 0; it < sh_iter; it++) begin
			x2 = (x * x) >>> 24;
			y2 = (y * y) >>> 24;
			z2 = (z * z) >>> 24;
			ra = x2 - y2;
			rb = x2 - z2;
			ovf = 1'b0;
			if (sh_fold1[0]) ra = abs_l(ra);
			if (sh_fold2[0]) rb = abs_l(rb);
			nx = sat_coord(ra + rb - x2 + cx, ovf);
			ny = sat_coord(cross_term(x, y, sh_fold1) + cy, ovf);
			nz = sat_coord(cross_term(x, z, sh_fold2) + cz, ovf);
			if (ovf || norm2(nx, ny, nz) > bail2) begin
				esc = 1'b1;
				break;
			end
			x = nx; y = ny; z = nz;
		end
		if (esc) begin
			val = 32768 + (32768 * it) / sh_iter;
			r.voxel_value = val[15:0];
			r.escaped = 1'b1;
			r.iteration_count = it[15:0];
		end else begin
			val = 31457;
			if (sh_bail != 0) begin
				mag = int_sqrt(norm2(x, y, z));
				t = (mag * 31457) / sh_bail;
				if (t < val) val = t;
			end
			r.voxel_value = val[15:0];
			r.escaped = 1'b0;
			r.iteration_count = sh_iter[15:0];
		end
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_voxels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		start <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_X_MIN:       sh_xmin = longint'($signed(data));
			CFG_Y_MIN:       sh_ymin = longint'($signed(data));
			CFG_Z_MIN:       sh_zmin = longint'($signed(data));
			CFG_VOXEL_STEP:  sh_step = data[30:0];
			CFG_BAILOUT:     sh_bail = data[30:0];
			CFG_MAX_ITER:    sh_iter = data[15:0];
			CFG_FOLD_FIRST:  sh_fold1 = data[3:0];
			CFG_FOLD_SECOND: sh_fold2 = data[3:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_voxel(f3v_in_t v, bit typed, f3v_out_t known, bit gaps);
		start <= 1'b1;
		voxel <= v;
		do @(posedge clk); while (busy);
		pending_voxels.push_back(typed ? known : eval_voxel(v));
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_voxels.size() == 0) begin
				$display("%0t unexpected result %h", $time, result);
				errors++;
			end else begin
				f3v_out_t e;
				e = pending_voxels.pop_front();
				if (result.voxel_value !== e.voxel_value) begin
					$display("%0t voxel_value exp %0d got %0d", $time,
						e.voxel_value, result.voxel_value);
					errors++;
				end
				if (result.escaped !== e.escaped) begin
					$display("%0t escaped exp %0d got %0d", $time, e.escaped, result.escaped);
					errors++;
				end
				if (result.iteration_count !== e.iteration_count) begin
					$display("%0t iteration_count exp %0d got %0d", $time,
						e.iteration_count, result.iteration_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	stim_row_t dir_rows[$];

	initial begin
		f3v_in_t   v;
		f3v_out_t  none;
		int        sent, batch, pick;
		logic [31:0] w;
		none = '0;
		sh_xmin = 0; sh_ymin = 0; sh_zmin = 0; sh_step = 0;
		sh_bail = BAILOUT_RESET; sh_iter = MAX_ITER_RESET; sh_fold1 = 0; sh_fold2 = 0;
		dir_rows = '{
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b1, {16'd0, 1'b0, 16'd64}},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd1023, 10'd1023, 10'd1023}, 1'b1,
				{16'd0, 1'b0, 16'd64}},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd682, 10'd341, 10'd1023}, 1'b1,
				{16'd0, 1'b0, 16'd64}},
			'{1'b1, CFG_MAX_ITER, 32'd0, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd5, 10'd9, 10'd1}, 1'b1, {16'd0, 1'b0, 16'd0}},
			'{1'b1, CFG_MAX_ITER, 32'd1, '0, 1'b0, '0},
			'{1'b1, CFG_BAILOUT, 32'd0, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b1, {16'd31457, 1'b0, 16'd1}},
			'{1'b1, CFG_BAILOUT, 32'h0400_0000, '0, 1'b0, '0},
			'{1'b1, CFG_MAX_ITER, 32'd16, '0, 1'b0, '0},
			'{1'b1, CFG_VOXEL_STEP, 32'h0001_0000, '0, 1'b0, '0},
			'{1'b1, CFG_X_MIN, 32'hFE00_0000, '0, 1'b0, '0},
			'{1'b1, CFG_Y_MIN, 32'hFE00_0000, '0, 1'b0, '0},
			'{1'b1, CFG_Z_MIN, 32'hFE00_0000, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd512, 10'd512, 10'd512}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd300, 10'd600, 10'd200}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd700, 10'd500, 10'd520}, 1'b0, '0},
			'{1'b1, CFG_FOLD_FIRST, 32'd15, '0, 1'b0, '0},
			'{1'b1, CFG_FOLD_SECOND, 32'd15, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd400, 10'd512, 10'd600}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd256, 10'd700, 10'd300}, 1'b0, '0},
			'{1'b1, CFG_FOLD_FIRST, 32'd6, '0, 1'b0, '0},
			'{1'b1, CFG_FOLD_SECOND, 32'd9, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd350, 10'd512, 10'd512}, 1'b0, '0},
			'{1'b1, CFG_X_MIN, 32'h7FFF_FFFF, '0, 1'b0, '0},
			'{1'b1, CFG_VOXEL_STEP, 32'h7FFF_FFFF, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd1023, 10'd0, 10'd1023}, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b0, '0},
			'{1'b1, CFG_X_MIN, 32'h8000_0000, '0, 1'b0, '0},
			'{1'b1, CFG_Y_MIN, 32'h8000_0000, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b0, '0},
			'{1'b1, CFG_BAILOUT, 32'h7FFF_FFFF, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd1, 10'd2, 10'd3}, 1'b0, '0},
			'{1'b1, CFG_X_MIN, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_Y_MIN, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_Z_MIN, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_VOXEL_STEP, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_BAILOUT, 32'h0400_0000, '0, 1'b0, '0},
			'{1'b1, CFG_FOLD_FIRST, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_FOLD_SECOND, 32'd0, '0, 1'b0, '0},
			'{1'b1, CFG_MAX_ITER, 32'd65535, '0, 1'b0, '0},
			'{1'b0, CFG_X_MIN, 32'd0, {10'd0, 10'd0, 10'd0}, 1'b1, {16'd0, 1'b0, 16'd65535}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
			else send_voxel(dir_rows[i].vox, dir_rows[i].typed, dir_rows[i].known, 1'b1);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			for (int r = 0; r < 3; r++) begin
				pick = $urandom_range(0, 9);
				w = (pick < 8) ? 32'hFD80_0000 + $urandom_range(0, 32'h0280_0000) : $urandom;
				write_reg(CFG_X_MIN + r[2:0], w);
			end
			pick = $urandom_range(0, 19);
			w = (pick < 14) ? $urandom_range(1, 32'h0002_0000) : (pick < 17) ? 32'd0 : $urandom;
			write_reg(CFG_VOXEL_STEP, w);
			pick = $urandom_range(0, 9);
			w = (pick < 7) ? $urandom_range(32'h0100_0000, 32'h0800_0000) :
				(pick < 8) ? 32'd0 : $urandom;
			write_reg(CFG_BAILOUT, w);
			pick = $urandom_range(0, 19);
			w = (pick < 17) ? $urandom_range(1, 48) : (pick < 18) ? 32'd0 :
				$urandom_range(49, 200);
			write_reg(CFG_MAX_ITER, w);
			write_reg(CFG_FOLD_FIRST, $urandom);
			write_reg(CFG_FOLD_SECOND, $urandom);
			batch = $urandom_range(20, 60);
			for (int k = 0; k < batch && sent < RANDOM_ITEMS; k++) begin
				v = 30'($urandom);
				if ($urandom_range(0, 4) == 0) v.x_index = 10'($urandom_range(0, 7));
				if (k == batch / 2 && $urandom_range(0, 1) == 0) begin
					start <= 1'b0;
					wait_drained();
				end
				send_voxel(v, 1'b0, none, sent < RANDOM_ITEMS - CALM_TAIL);
				sent++;
			end
		end
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
